// ----- rtl/core/iaf_pkg.sv -----
// Shared types, constants and helper functions of the attitude fusion core.
package iaf_pkg;

  localparam int DW = 64;       // main datapath word
  localparam int CW = 40;       // CORDIC vector width, Q.30 with headroom
  localparam int AW = 32;       // CORDIC angle accumulator, Q.16 centidegrees
  localparam int TAB_LEN = 30;
  localparam int TIW = $clog2(TAB_LEN);

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [CW-1:0] cvec_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

  localparam word_t GYRO_K40 = 64'sd1199381129;   // pi/2880 in Q0.40
  localparam word_t US_PER_S = 64'sd1000000;
  localparam word_t US_PER_S2 = 64'sd2000000;
  localparam angle_t DEG90_Q16 = 32'sd589824000;

  function automatic angle_t atan_entry(input logic [TIW-1:0] i);
    angle_t v;
    unique case (i)
      5'd0: v = 32'sd294912000;
      5'd1: v = 32'sd174096719;
      5'd2: v = 32'sd91987925;
      5'd3: v = 32'sd46694507;
      5'd4: v = 32'sd23437865;
      5'd5: v = 32'sd11730358;
      5'd6: v = 32'sd5866610;
      5'd7: v = 32'sd2933484;
      5'd8: v = 32'sd1466764;
      5'd9: v = 32'sd733385;
      5'd10: v = 32'sd366693;
      5'd11: v = 32'sd183346;
      5'd12: v = 32'sd91673;
      5'd13: v = 32'sd45837;
      5'd14: v = 32'sd22918;
      5'd15: v = 32'sd11459;
      5'd16: v = 32'sd5730;
      5'd17: v = 32'sd2865;
      5'd18: v = 32'sd1432;
      5'd19: v = 32'sd716;
      5'd20: v = 32'sd358;
      5'd21: v = 32'sd179;
      5'd22: v = 32'sd90;
      5'd23: v = 32'sd45;
      5'd24: v = 32'sd22;
      5'd25: v = 32'sd11;
      5'd26: v = 32'sd6;
      5'd27: v = 32'sd3;
      5'd28: v = 32'sd1;
      5'd29: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Shift right with rounding to nearest, halves away from zero.
  function automatic word_t rnd_shr(input word_t v, input int unsigned s);
    logic [DW-1:0] m;
    m = v[DW-1] ? (~v + 64'd1) : v;
    if (s != 0) m = (m + (64'd1 << (s - 1))) >> s;
    return v[DW-1] ? word_t'(~m + 64'd1) : word_t'(m);
  endfunction

  function automatic logic signed [31:0] sat32(input word_t v);
    logic signed [31:0] r;
    if (v > $signed(64'h0000_0000_7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < $signed(64'hFFFF_FFFF_8000_0000)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/iaf_arith_unit.sv -----
// Shared iterative unit: multiply, rounded signed divide and integer square root.
module iaf_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  iaf_pkg::arith_ctl_t ctl,
  input  iaf_pkg::word_t     a,
  input  iaf_pkg::word_t     b,
  output logic               done,
  output iaf_pkg::word_t     res
);
  import iaf_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_SQRT} ustate_t;

  ustate_t       ust;
  logic [6:0]    cnt;
  logic [DW-1:0] acc, opa, opb, rem;
  logic          neg;

  logic [DW+3:0] pp;
  logic [DW-1:0] mul_sum;
  logic [DW:0]   rem_sh, div_sub;
  logic          div_ge;
  logic [DW-1:0] div_quo, div_rem;
  logic [DW-1:0] sq_rb, sq_r;
  logic          sq_ge;

  always_comb begin
    // multiply: four multiplier bits per cycle
    pp = opa * opb[3:0];
    mul_sum = acc + pp[DW-1:0];
    // divide: one quotient bit per cycle, dividend shifts through opa
    rem_sh = {rem, opa[DW-1]};
    div_sub = rem_sh - {1'b0, opb};
    div_ge = rem_sh >= {1'b0, opb};
    div_quo = {opa[DW-2:0], div_ge};
    div_rem = div_ge ? div_sub[DW-1:0] : rem_sh[DW-1:0];
    // square root: one root bit per cycle
    sq_rb = opa + opb;
    sq_ge = acc >= sq_rb;
    sq_r = sq_ge ? ((opa >> 1) + opb) : (opa >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ust <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ust)
        U_IDLE: begin
          if (ctl.start) begin
            cnt <= '0;
            unique case (ctl.op)
              OP_MUL: begin
                acc <= '0;
                opa <= a;
                opb <= b;
                ust <= U_MUL;
              end
              OP_DIV: begin
                neg <= a[DW-1];
                rem <= '0;
                opa <= (a[DW-1] ? -a : a) + (b >> 1);
                opb <= b;
                ust <= U_DIV;
              end
              OP_SQRT: begin
                acc <= a;
                opa <= '0;
                opb <= 64'd1 << (DW - 2);
                ust <= U_SQRT;
              end
              default: ust <= U_IDLE;
            endcase
          end
        end
        U_MUL: begin
          acc <= mul_sum;
          opa <= opa << 4;
          opb <= opb >> 4;
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DW / 4 - 1)) begin
            res <= word_t'(mul_sum);
            done <= 1'b1;
            ust <= U_IDLE;
          end
        end
        U_DIV: begin
          rem <= div_rem;
          opa <= div_quo;
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DW - 1)) begin
            res <= neg ? word_t'(~div_quo + 64'd1) : word_t'(div_quo);
            done <= 1'b1;
            ust <= U_IDLE;
          end
        end
        U_SQRT: begin
          if (sq_ge) acc <= acc - sq_rb;
          opa <= sq_r;
          opb <= opb >> 2;
          cnt <= cnt + 7'd1;
          if (cnt == 7'(DW / 2 - 1)) begin
            res <= word_t'(sq_r);
            done <= 1'b1;
            ust <= U_IDLE;
          end
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/iaf_cordic.sv -----
// Iterative vectoring CORDIC: atan2 in Q.16 centidegrees, one step per cycle.
module iaf_cordic #(
  parameter int STEPS = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  iaf_pkg::cvec_t  yin,
  input  iaf_pkg::cvec_t  xin,
  output logic            done,
  output iaf_pkg::angle_t zout
);
  import iaf_pkg::*;

  logic           busy;
  logic [TIW-1:0] i;
  cvec_t          x, y, dx, dy, x_next, y_next;
  angle_t         z, z_next, tab;

  always_comb begin
    dx = y >>> i;
    dy = x >>> i;
    tab = atan_entry(i);
    if (y < 0) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - tab;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + tab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          i <= '0;
          if (xin == 0 && yin == 0) begin
            zout <= '0;
            done <= 1'b1;
          end else begin
            busy <= 1'b1;
            // rotate into the right half plane first
            if (xin < 0) begin
              if (yin >= 0) begin
                x <= yin;
                y <= -xin;
                z <= DEG90_Q16;
              end else begin
                x <= -yin;
                y <= xin;
                z <= -DEG90_Q16;
              end
            end else begin
              x <= xin;
              y <= yin;
              z <= '0;
            end
          end
        end
      end else begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        i <= i + 1'b1;
        if (i == TIW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          zout <= z_next;
        end
      end
    end
  end

endmodule

// ----- rtl/core/imu_attitude_fusion_core.sv -----
// Top level of the IMU attitude fusion core: sequencer, state and channels.
// Usage:
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (0: Kp,
//   1: Ki, unsigned Q0.16) at the clock edge; write only while idle.
//   Input: one accelerometer/gyro sample plus step_us moves per transfer on
//   in_valid/in_ready. in_ready is high only while the sequencer is idle.
//   Output: one pitch/roll/yaw result per sample on out_valid/out_ready,
//   held in an output register; the next sample is taken while it waits.
//   Processing: each sample is worked through step by step on the single shared
//   multiply/divide/root unit (4 product bits, 1 quotient bit or 1 root
//   bit per cycle) and then three CORDIC runs; a sample without
//   accelerometer correction skips the correction steps. A new sample is
//   taken only after the last one is finished; a stalled receiver holds the
//   finished result, and the sequencer waits before writing the following one.
//   Reset: quaternion to identity, integral terms to zero, gains to their
//   defaults, both channels empty.
module imu_attitude_fusion_core #(
  parameter int FRAC_BITS = 30,
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic [15:0]        step_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] pitch_cdeg,
  output logic signed [15:0] roll_cdeg,
  output logic signed [15:0] yaw_cdeg,
  output logic               accel_used
);
  import iaf_pkg::*;

  localparam word_t ONE = 64'sd1 <<< FRAC_BITS;
  localparam word_t ONE_SQ = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic CFG_KP = 1'b0;
  localparam logic CFG_KI = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_G, ST_A, ST_ASQ, ST_AN, ST_M0, ST_M1, ST_E0, ST_E1,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_H0, ST_H1, ST_Q, ST_N, ST_NSQ, ST_ND,
    ST_CL, ST_C, ST_CSQ, ST_K, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] hi;
    logic       neg;
  } qterm_t;

  state_t st;
  logic [15:0] prop_gain, integ_gain;
  logic signed [15:0] araw [3];
  logic signed [15:0] rate_r [3];
  logic [15:0] st_r;
  logic used;
  word_t an [3];
  word_t gv [3];
  word_t ev [3];
  word_t hv [3];
  word_t nq [4];
  word_t row [5];    // r20, r21, r22, r10, r00
  logic signed [31:0] integ [3];
  logic signed [31:0] q [4];
  word_t acc, tmp, rr, cc;
  logic [1:0] ix, kk;
  logic [2:0] pi;
  logic pass2, pend;
  logic signed [14:0] ang_p;
  logic signed [15:0] ang_r, ang_y;

  arith_ctl_t u_ctl;
  word_t u_a, u_b, u_res;
  logic u_done;
  logic c_start, c_done;
  cvec_t c_y, c_x;
  angle_t c_z;

  qterm_t qt;
  word_t ysh, xsh, term, acc_q, pv, rv, cd;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic qterm_t q_term(input logic [1:0] j, input logic [1:0] k);
    qterm_t t;
    unique case ({j, k})
      4'b00_00: t = '{qi: 2'd1, hi: 2'd0, neg: 1'b1};
      4'b00_01: t = '{qi: 2'd2, hi: 2'd1, neg: 1'b1};
      4'b00_10: t = '{qi: 2'd3, hi: 2'd2, neg: 1'b1};
      4'b01_00: t = '{qi: 2'd0, hi: 2'd0, neg: 1'b0};
      4'b01_01: t = '{qi: 2'd2, hi: 2'd2, neg: 1'b0};
      4'b01_10: t = '{qi: 2'd3, hi: 2'd1, neg: 1'b1};
      4'b10_00: t = '{qi: 2'd0, hi: 2'd1, neg: 1'b0};
      4'b10_01: t = '{qi: 2'd1, hi: 2'd2, neg: 1'b1};
      4'b10_10: t = '{qi: 2'd3, hi: 2'd0, neg: 1'b0};
      4'b11_00: t = '{qi: 2'd0, hi: 2'd2, neg: 1'b0};
      4'b11_01: t = '{qi: 2'd1, hi: 2'd1, neg: 1'b0};
      4'b11_10: t = '{qi: 2'd2, hi: 2'd0, neg: 1'b1};
      default:  t = '{qi: 2'd0, hi: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

  // quaternion index pairs for the matrix entries, first and second product
  function automatic logic [3:0] pair_sel(input logic [2:0] p, input logic second);
    logic [3:0] s;
    unique case ({p, second})
      4'b000_0: s = {2'd1, 2'd3};
      4'b000_1: s = {2'd0, 2'd2};
      4'b001_0: s = {2'd2, 2'd3};
      4'b001_1: s = {2'd0, 2'd1};
      4'b010_0: s = {2'd1, 2'd1};
      4'b010_1: s = {2'd2, 2'd2};
      4'b011_0: s = {2'd1, 2'd2};
      4'b011_1: s = {2'd0, 2'd3};
      4'b100_0: s = {2'd2, 2'd2};
      4'b100_1: s = {2'd3, 2'd3};
      default:  s = '0;
    endcase
    return s;
  endfunction

  assign in_ready = (st == ST_IDLE);

  // operand selection for the shared unit and the CORDIC
  always_comb begin
    logic [3:0] ps;
    ps = pair_sel(pi, st == ST_M1);
    qt = q_term(ix, kk);
    u_ctl.op = OP_MUL;
    u_a = '0;
    u_b = '0;
    ysh = '0;
    xsh = '0;
    unique case (st)
      ST_G: begin
        u_a = word_t'(rate_r[ix]);
        u_b = GYRO_K40;
      end
      ST_A: begin
        u_a = word_t'(araw[ix]);
        u_b = word_t'(araw[ix]);
      end
      ST_ASQ: begin
        u_ctl.op = OP_SQRT;
        u_a = acc <<< 30;
      end
      ST_AN: begin
        u_ctl.op = OP_DIV;
        u_a = word_t'(araw[ix]) <<< (FRAC_BITS + 15);
        u_b = rr;
      end
      ST_M0, ST_M1: begin
        u_a = word_t'(q[ps[3:2]]);
        u_b = word_t'(q[ps[1:0]]);
      end
      ST_E0: begin
        u_a = an[nxt3(ix)];
        u_b = row[3'(nxt3(nxt3(ix)))];
      end
      ST_E1: begin
        u_a = an[nxt3(nxt3(ix))];
        u_b = row[3'(nxt3(ix))];
      end
      ST_I0: begin
        u_a = ev[ix];
        u_b = word_t'(integ_gain);
      end
      ST_I1, ST_H1: begin
        u_a = tmp;
        u_b = word_t'(st_r);
        if (st == ST_H1) begin
          u_ctl.op = OP_DIV;
          u_b = US_PER_S2;
        end
      end
      ST_I2: begin
        u_ctl.op = OP_DIV;
        u_a = tmp;
        u_b = US_PER_S;
      end
      ST_I3: begin
        u_a = ev[ix];
        u_b = word_t'(prop_gain);
      end
      ST_H0: begin
        u_a = gv[ix];
        u_b = word_t'(st_r);
      end
      ST_Q: begin
        u_a = word_t'(q[qt.qi]);
        u_b = hv[qt.hi];
      end
      ST_N: begin
        u_a = nq[ix];
        u_b = nq[ix];
      end
      ST_NSQ: begin
        u_ctl.op = OP_SQRT;
        u_a = acc;
      end
      ST_ND: begin
        u_ctl.op = OP_DIV;
        u_a = nq[ix] <<< FRAC_BITS;
        u_b = rr;
      end
      ST_C: begin
        u_a = row[0];
        u_b = row[0];
      end
      ST_CSQ: begin
        u_ctl.op = OP_SQRT;
        u_a = tmp;
      end
      ST_K: begin
        unique case (ix)
          2'd0: begin
            ysh = row[0];
            xsh = cc;
          end
          2'd1: begin
            ysh = row[1];
            xsh = row[2];
          end
          default: begin
            ysh = row[3];
            xsh = row[4];
          end
        endcase
        ysh = ysh <<< (30 - FRAC_BITS);
        xsh = xsh <<< (30 - FRAC_BITS);
      end
      default: u_ctl.op = OP_MUL;
    endcase
    u_ctl.start = !pend && st != ST_IDLE && st != ST_CL && st != ST_K && st != ST_DONE;
    c_start = !pend && st == ST_K;
    c_y = ysh[CW-1:0];
    c_x = xsh[CW-1:0];
  end

  // writeback helpers
  always_comb begin
    term = qt.neg ? -u_res : u_res;
    acc_q = (kk == 2'd0) ? term : acc + term;
    pv = (pi == 3'd0) ? acc - u_res : acc + u_res;
    rv = rnd_shr(pv <<< 1, FRAC_BITS);
    if (pi == 3'd2 || pi == 3'd4) rv = ONE - rv;
    cd = rnd_shr(word_t'(c_z), 16);
    if (ix == 2'd0) begin
      if (cd > 64'sd9000) cd = 64'sd9000;
      if (cd < -64'sd9000) cd = -64'sd9000;
    end else begin
      if (cd > 64'sd18000) cd = 64'sd18000;
      if (cd < -64'sd18000) cd = -64'sd18000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      pend <= 1'b0;
      out_valid <= 1'b0;
      prop_gain <= 16'd2621;
      integ_gain <= 16'd66;
      q[0] <= 32'(ONE);
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
      integ[0] <= '0;
      integ[1] <= '0;
      integ[2] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_KP: prop_gain <= cfg_wdata;
          CFG_KI: integ_gain <= cfg_wdata;
          default: prop_gain <= prop_gain;
        endcase
      end
      if (out_valid && out_ready && st != ST_DONE) out_valid <= 1'b0;
      if (u_ctl.start || c_start) pend <= 1'b1;
      if (u_done || c_done) pend <= 1'b0;

      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            araw[0] <= accel_x;
            araw[1] <= accel_y;
            araw[2] <= accel_z;
            rate_r[0] <= rate_x;
            rate_r[1] <= rate_y;
            rate_r[2] <= rate_z;
            st_r <= step_us;
            used <= (accel_x != 0) || (accel_y != 0) || (accel_z != 0);
            ix <= '0;
            st <= ST_G;
          end
        end
        ST_G: if (u_done) begin
          gv[ix] <= rnd_shr(u_res, 40 - FRAC_BITS);
          ix <= nxt3(ix);
          if (ix == 2'd2) st <= used ? ST_A : ST_H0;
        end
        ST_A: if (u_done) begin
          acc <= (ix == 2'd0) ? u_res : acc + u_res;
          ix <= nxt3(ix);
          if (ix == 2'd2) st <= ST_ASQ;
        end
        ST_ASQ: if (u_done) begin
          rr <= u_res;
          st <= ST_AN;
        end
        ST_AN: if (u_done) begin
          an[ix] <= u_res;
          ix <= nxt3(ix);
          if (ix == 2'd2) begin
            pi <= '0;
            pass2 <= 1'b0;
            st <= ST_M0;
          end
        end
        ST_M0: if (u_done) begin
          acc <= u_res;
          st <= ST_M1;
        end
        ST_M1: if (u_done) begin
          row[pi] <= rv;
          if (pass2 ? (pi == 3'd4) : (pi == 3'd2)) begin
            ix <= '0;
            st <= pass2 ? ST_CL : ST_E0;
          end else begin
            pi <= pi + 3'd1;
            st <= ST_M0;
          end
        end
        ST_E0: if (u_done) begin
          acc <= u_res;
          st <= ST_E1;
        end
        ST_E1: if (u_done) begin
          ev[ix] <= rnd_shr(acc - u_res, FRAC_BITS);
          ix <= nxt3(ix);
          st <= (ix == 2'd2) ? ST_I0 : ST_E0;
        end
        ST_I0: if (u_done) begin
          tmp <= rnd_shr(u_res, 16);
          st <= ST_I1;
        end
        ST_I1: if (u_done) begin
          tmp <= u_res;
          st <= ST_I2;
        end
        ST_I2: if (u_done) begin
          integ[ix] <= sat32(word_t'(integ[ix]) + u_res);
          st <= ST_I3;
        end
        ST_I3: if (u_done) begin
          gv[ix] <= gv[ix] + rnd_shr(u_res, 16) + word_t'(integ[ix]);
          ix <= nxt3(ix);
          st <= (ix == 2'd2) ? ST_H0 : ST_I0;
        end
        ST_H0: if (u_done) begin
          tmp <= u_res;
          st <= ST_H1;
        end
        ST_H1: if (u_done) begin
          hv[ix] <= u_res;
          ix <= nxt3(ix);
          kk <= '0;
          st <= (ix == 2'd2) ? ST_Q : ST_H0;
        end
        ST_Q: if (u_done) begin
          acc <= acc_q;
          if (kk == 2'd2) begin
            nq[ix] <= word_t'(q[ix]) + rnd_shr(acc_q, FRAC_BITS);
            kk <= '0;
            ix <= ix + 2'd1;
            if (ix == 2'd3) st <= ST_N;
          end else begin
            kk <= kk + 2'd1;
          end
        end
        ST_N: if (u_done) begin
          acc <= (ix == 2'd0) ? u_res : acc + u_res;
          ix <= ix + 2'd1;
          if (ix == 2'd3) st <= ST_NSQ;
        end
        ST_NSQ: if (u_done) begin
          rr <= u_res;
          ix <= '0;
          pi <= '0;
          if (u_res == 0) begin
            // degenerate norm: fall back to identity
            q[0] <= 32'(ONE);
            q[1] <= '0;
            q[2] <= '0;
            q[3] <= '0;
            pass2 <= 1'b1;
            st <= ST_M0;
          end else begin
            st <= ST_ND;
          end
        end
        ST_ND: if (u_done) begin
          q[ix] <= sat32(u_res);
          ix <= ix + 2'd1;
          if (ix == 2'd3) begin
            pass2 <= 1'b1;
            st <= ST_M0;
          end
        end
        ST_CL: begin
          if (row[0] > ONE) row[0] <= ONE;
          if (row[0] < -ONE) row[0] <= -ONE;
          st <= ST_C;
        end
        ST_C: if (u_done) begin
          tmp <= ONE_SQ - u_res;
          st <= ST_CSQ;
        end
        ST_CSQ: if (u_done) begin
          cc <= u_res;
          ix <= '0;
          st <= ST_K;
        end
        ST_K: if (c_done) begin
          unique case (ix)
            2'd0: ang_p <= 15'(-cd);
            2'd1: ang_r <= cd[15:0];
            default: ang_y <= cd[15:0];
          endcase
          ix <= nxt3(ix);
          if (ix == 2'd2) st <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            pitch_cdeg <= ang_p;
            roll_cdeg <= ang_r;
            yaw_cdeg <= ang_y;
            accel_used <= used;
            out_valid <= 1'b1;
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  iaf_arith_unit u_arith (
    .clk  (clk),
    .rst  (rst),
    .ctl  (u_ctl),
    .a    (u_a),
    .b    (u_b),
    .done (u_done),
    .res  (u_res)
  );

  iaf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .yin   (c_y),
    .xin   (c_x),
    .done  (c_done),
    .zout  (c_z)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while sequencer busy");
  a_done_needs_pend: assert property (@(posedge clk) disable iff (rst)
    (u_done || c_done) |-> pend)
    else $error("unit finished without a pending operation");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    st == ST_IDLE |-> !pend)
    else $error("operation pending while idle");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == ST_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

// ----- bench/imu_attitude_fusion_core_test.sv -----
// Self-checking bench for the IMU attitude fusion core.
`timescale 1ns / 100ps

module imu_attitude_fusion_core_test;
  import iaf_pkg::*;

  localparam int FB = 30;
  localparam int STEPS = 20;
  localparam longint ONE = 64'sd1 << FB;
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE = 3000;

  localparam logic REG_KP = 1'b0;
  localparam logic REG_KI = 1'b1;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic used;
  } attitude_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0, cfg_addr = 0;
  logic [15:0] cfg_wdata = 0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic signed [15:0] rate_x = 0, rate_y = 0, rate_z = 0;
  logic [15:0] step_us = 1;
  logic out_valid, out_ready = 0;
  logic signed [14:0] pitch_cdeg;
  logic signed [15:0] roll_cdeg, yaw_cdeg;
  logic accel_used;

  imu_attitude_fusion_core dut (.*);

  always #5 clk = ~clk;

  // Mirror of the fusion state.
  longint kp_q16, ki_q16;
  longint qw, qx, qy, qz, iex, iey, iez;
  attitude_t pending_att[$];
  int errors = 0, sent = 0, got = 0, idle_cycles = 0;
  bit out_throttle = 1;

  function automatic longint shr_rnd(longint v, int s);
    longint m;
    if (s == 0) return v;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_near(longint n, longint d);
    longint m;
    m = n < 0 ? -n : n;
    m = (m + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan2_q16(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = DEG90_Q16;
      end else begin
        x = -y; y = t; z = -longint'(DEG90_Q16);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic longint cdeg(longint z, longint lim);
    longint c;
    c = shr_rnd(z, 16);
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    return c;
  endfunction

  function automatic longint twice_prod(longint a, longint b, longint c, longint d);
    return shr_rnd(2 * (a * b + c * d), FB);
  endfunction

  function automatic attitude_t fuse_sample(longint ax, longint ay, longint az,
      longint rx, longint ry, longint rz, longint st);
    attitude_t res;
    longint gx, gy, gz, w, x, y, z, r, ex, ey, ez, r00, r10, r20, r21, r22, c;
    longint hx, hy, hz, nw, nx, ny, nz;
    longint unsigned s, n;
    bit used;
    gx = shr_rnd(rx * GYRO_K40, 40 - FB);
    gy = shr_rnd(ry * GYRO_K40, 40 - FB);
    gz = shr_rnd(rz * GYRO_K40, 40 - FB);
    w = qw; x = qx; y = qy; z = qz;
    used = (ax != 0 || ay != 0 || az != 0);
    if (used) begin
      s = ax * ax + ay * ay + az * az;
      r = root64(s << 30);
      ax = div_near(ax * (64'sd1 << (FB + 15)), r);
      ay = div_near(ay * (64'sd1 << (FB + 15)), r);
      az = div_near(az * (64'sd1 << (FB + 15)), r);
      r20 = twice_prod(x, z, -w, y);
      r21 = twice_prod(y, z, w, x);
      r22 = ONE - shr_rnd(2 * (x * x + y * y), FB);
      ex = shr_rnd(ay * r22 - az * r21, FB);
      ey = shr_rnd(az * r20 - ax * r22, FB);
      ez = shr_rnd(ax * r21 - ay * r20, FB);
      iex = clamp32(iex + div_near(shr_rnd(ex * ki_q16, 16) * st, 1000000));
      iey = clamp32(iey + div_near(shr_rnd(ey * ki_q16, 16) * st, 1000000));
      iez = clamp32(iez + div_near(shr_rnd(ez * ki_q16, 16) * st, 1000000));
      gx += shr_rnd(ex * kp_q16, 16) + iex;
      gy += shr_rnd(ey * kp_q16, 16) + iey;
      gz += shr_rnd(ez * kp_q16, 16) + iez;
    end
    hx = div_near(gx * st, 2000000);
    hy = div_near(gy * st, 2000000);
    hz = div_near(gz * st, 2000000);
    nw = w + shr_rnd(-x * hx - y * hy - z * hz, FB);
    nx = x + shr_rnd(w * hx + y * hz - z * hy, FB);
    ny = y + shr_rnd(w * hy - x * hz + z * hx, FB);
    nz = z + shr_rnd(w * hz + x * hy - y * hx, FB);
    s = longint'(nw * nw) + longint'(nx * nx) + longint'(ny * ny) + longint'(nz * nz);
    n = root64(s);
    if (n == 0) begin
      w = ONE; x = 0; y = 0; z = 0;
    end else begin
      w = div_near(nw * ONE, n);
      x = div_near(nx * ONE, n);
      y = div_near(ny * ONE, n);
      z = div_near(nz * ONE, n);
    end
    qw = clamp32(w); qx = clamp32(x); qy = clamp32(y); qz = clamp32(z);
    w = qw; x = qx; y = qy; z = qz;
    r20 = twice_prod(x, z, -w, y);
    r21 = twice_prod(y, z, w, x);
    r22 = ONE - shr_rnd(2 * (x * x + y * y), FB);
    r10 = twice_prod(x, y, w, z);
    r00 = ONE - shr_rnd(2 * (y * y + z * z), FB);
    if (r20 > ONE) r20 = ONE;
    if (r20 < -ONE) r20 = -ONE;
    c = root64(ONE * ONE - r20 * r20);
    res.pitch = 15'(-cdeg(atan2_q16(r20, c), 9000));
    res.roll = 16'(cdeg(atan2_q16(r21, r22), 18000));
    res.yaw = 16'(cdeg(atan2_q16(r10, r00), 18000));
    res.used = used;
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_sample(logic [15:0] ax, ay, az, rx, ry, rz, st);
    // step off the falling edge where valid was dropped
    repeat (gap_len() + 1) @(negedge clk);
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    rate_x <= rx; rate_y <= ry; rate_z <= rz;
    step_us <= st;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    pending_att.push_back(fuse_sample($signed(ax), $signed(ay), $signed(az),
      $signed(rx), $signed(ry), $signed(rz), st));
    sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (pending_att.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_gain(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_KP) kp_q16 = val; else ki_q16 = val;
  endtask

  // Send n samples with a level, gravity-like reading and small random rates.
  task automatic send_level(int n);
    repeat (n)
      send_sample(16'($urandom_range(0, 800)) - 16'd400,
        16'($urandom_range(0, 800)) - 16'd400, 16'd16384 + 16'($urandom_range(0, 400)),
        16'($urandom_range(0, 1600)) - 16'd800, 16'($urandom_range(0, 1600)) - 16'd800,
        16'($urandom_range(0, 1600)) - 16'd800, 16'($urandom_range(500, 2000)));
  endtask

  task automatic test_directed();
    send_sample(0, 0, 16384, 0, 0, 0, 1000);
    send_sample(0, 0, 0, 100, -100, 50, 1000);
    send_sample(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_sample(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 16'h8000, 1);
    send_sample(16'h8000, 0, 0, 0, 0, 0, 65535);
    send_sample(0, 16'h7FFF, 0, 0, 16'h7FFF, 0, 65535);
    send_sample(0, 0, 16'h8000, 0, 0, 16'h7FFF, 65535);
    send_sample(1, 0, 0, 16'h8000, 16'h7FFF, 0, 40000);
    send_sample(0, 0, 0, 0, 16'h7FFF, 0, 65535);
    send_sample(0, 0, 0, 0, 16'h7FFF, 0, 65535);
    send_sample(-1, -1, -1, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hAAAA);
    send_sample(0, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_gains();
    write_gain(REG_KP, 16'hFFFF);
    write_gain(REG_KI, 16'hFFFF);
    // Drive integral terms toward saturation.
    repeat (8) send_sample(16'h7FFF, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_level(6);
    drain();
    write_gain(REG_KP, 0);
    write_gain(REG_KI, 0);
    send_level(6);
    drain();
    write_gain(REG_KP, 16'h5555);
    write_gain(REG_KI, 16'h0123);
    send_level(6);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) begin
        drain();
        write_gain(REG_KP, 16'($urandom));
        write_gain(REG_KI, 16'($urandom_range(0, 4000)));
      end
      if ($urandom_range(0, 3) != 0) send_level(1);
      else send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0 ? 16'd0
        : 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
        16'($urandom_range(0, 65535)));
    end
  endtask

  // Receiver: throttle ready, check each transfer against the oldest prediction.
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (!out_throttle) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) begin
    attitude_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    if (!rst && out_valid && out_ready) begin
      got++;
      if (pending_att.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_att.pop_front();
        if (pitch_cdeg !== e.pitch) begin
          $error("pitch_cdeg exp %0d got %0d", e.pitch, pitch_cdeg); errors++;
        end
        if (roll_cdeg !== e.roll) begin
          $error("roll_cdeg exp %0d got %0d", e.roll, roll_cdeg); errors++;
        end
        if (yaw_cdeg !== e.yaw) begin
          $error("yaw_cdeg exp %0d got %0d", e.yaw, yaw_cdeg); errors++;
        end
        if (accel_used !== e.used) begin
          $error("accel_used exp %0d got %0d", e.used, accel_used); errors++;
        end
      end
    end
  end

  initial begin
    kp_q16 = 2621; ki_q16 = 66;
    qw = ONE; qx = 0; qy = 0; qz = 0;
    iex = 0; iey = 0; iez = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_gains();
    out_throttle = 0;
    send_level(20);
    out_throttle = 1;
    test_random(680);
    drain();
    if (pending_att.size() != 0) begin
      $error("%0d results never arrived", pending_att.size());
      errors++;
    end
    $display("Sent %0d samples, checked %0d attitudes over several gain settings,",
      sent, got);
    $display("zero accel, zero step, saturating integrals and full-scale rates.");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
